[rtl/core/pee_pkg.sv]
// Shared types and constants for the postfix expression evaluator.
package pee_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } pee_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } pee_out_t;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_MUL  = 3'd1,
    OP_DIV  = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4,
    OP_POW  = 3'd5
  } pee_op_t;

  // Decoded request passed from the front end to the execute unit.
  typedef struct packed {
    pee_op_t     op;
    logic [31:0] imm;
    logic        last;
  } pee_cmd_t;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW     = 3'd2;
  localparam logic [2:0] ST_DIVZERO      = 3'd3;
  localparam logic [2:0] ST_ZERO_NEG_POW = 3'd4;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_POW  = 8'h5E;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

endpackage

[rtl/core/pee_front.sv]
// Front end: request decode and a two-entry command queue.
module pee_front import pee_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  pee_in_t  in_req,
  output logic     in_full,
  output logic     cmd_valid,
  output pee_cmd_t cmd,
  input  logic     cmd_take
);

  pee_cmd_t   q_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;
  pee_cmd_t   dec;
  logic       do_push, do_pop;

  always_comb begin
    dec.last = in_req.end_of_expression;
    dec.imm  = {24'd0, in_req.symbol} - {24'd0, CH_ZERO};
    unique case (in_req.symbol)
      CH_MUL:  dec.op = OP_MUL;
      CH_DIV:  dec.op = OP_DIV;
      CH_ADD:  dec.op = OP_ADD;
      CH_SUB:  dec.op = OP_SUB;
      CH_POW:  dec.op = OP_POW;
      default: dec.op = OP_PUSH;
    endcase
  end

  assign in_full   = cnt_r == 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rd_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= dec;
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/core/pee_back.sv]
// Back end: operand stack, iterative divider and power loop, result register.
module pee_back import pee_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  pee_cmd_t cmd,
  output logic     cmd_take,
  output logic     out_empty,
  input  logic     out_pop,
  output pee_out_t out_res
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_POP1, S_POP2, S_CALC, S_DIV, S_POW, S_MUL2, S_PUSH, S_FIN, S_FIN2, S_OUT
  } state_t;

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rdata_r;

  state_t      st_r;
  logic [CW-1:0] cnt_r;
  logic [2:0]  err_r;
  pee_cmd_t    cmd_r;
  logic [31:0] rhs_r, lhs_r, res_r;
  logic [31:0] acc_r, base_r, ex_r;
  logic [31:0] quo_r, rem_r, num_r, den_r;
  logic        neg_r;
  logic [5:0]  it_r;
  logic        pop_ok_r;
  logic        out_v_r;
  pee_out_t    out_r;

  logic        can_pop;
  logic [AW-1:0] top_idx;
  logic [32:0] trial;
  logic [63:0] mul_a, mul_b;

  assign can_pop  = cnt_r != '0;
  assign top_idx  = AW'(cnt_r - CW'(1));
  assign cmd_take = st_r == S_IDLE && !out_v_r;
  assign out_empty = !out_v_r;
  assign out_res   = out_r;
  assign trial     = {rem_r, num_r[31]} - {1'b0, den_r};
  assign mul_a     = {32'd0, acc_r} * {32'd0, base_r};
  assign mul_b     = {32'd0, base_r} * {32'd0, base_r};

  always_ff @(posedge clk) begin
    rdata_r <= mem[top_idx];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_PUSH && cnt_r < DEPTH_C) mem[AW'(cnt_r)] <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cnt_r   <= '0;
      err_r   <= ST_OK;
      out_v_r <= 1'b0;
    end else begin
      if (out_pop && out_v_r) out_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (cmd_valid && !out_v_r) begin
            cmd_r <= cmd;
            res_r <= cmd.imm;
            st_r  <= (cmd.op == OP_PUSH) ? S_PUSH : S_POP1;
          end
        end
        S_POP1: begin
          // read data for the top entry is registered this cycle
          pop_ok_r <= can_pop;
          if (can_pop) cnt_r <= cnt_r - CW'(1);
          else if (err_r == ST_OK) err_r <= ST_UNDERFLOW;
          st_r <= S_POP2;
        end
        S_POP2: begin
          rhs_r    <= pop_ok_r ? rdata_r : ALL_ONES;
          pop_ok_r <= can_pop;
          if (can_pop) cnt_r <= cnt_r - CW'(1);
          else if (err_r == ST_OK) err_r <= ST_UNDERFLOW;
          st_r <= S_CALC;
        end
        S_CALC: begin
          lhs_r <= pop_ok_r ? rdata_r : ALL_ONES;
          st_r  <= S_MUL2;
        end
        S_MUL2: begin
          st_r <= S_PUSH;
          case (cmd_r.op)
            OP_ADD: res_r <= lhs_r + rhs_r;
            OP_SUB: res_r <= lhs_r - rhs_r;
            OP_MUL: begin
              acc_r <= lhs_r; base_r <= rhs_r; ex_r <= 32'd1;
              res_r <= 32'd0; it_r <= 6'd0; st_r <= S_POW;
            end
            OP_DIV: begin
              if (rhs_r == 32'd0) begin
                res_r <= 32'd0;
                if (err_r == ST_OK) err_r <= ST_DIVZERO;
              end else begin
                num_r <= lhs_r[31] ? -lhs_r : lhs_r;
                den_r <= rhs_r[31] ? -rhs_r : rhs_r;
                neg_r <= lhs_r[31] ^ rhs_r[31];
                rem_r <= 32'd0; quo_r <= 32'd0; it_r <= 6'd0;
                st_r  <= S_DIV;
              end
            end
            OP_POW: begin
              if (rhs_r[31]) begin
                if (lhs_r == 32'd1) res_r <= 32'd1;
                else if (lhs_r == ALL_ONES) res_r <= rhs_r[0] ? ALL_ONES : 32'd1;
                else begin
                  res_r <= 32'd0;
                  if (lhs_r == 32'd0 && err_r == ST_OK) err_r <= ST_ZERO_NEG_POW;
                end
              end else begin
                acc_r <= 32'd1; base_r <= lhs_r; ex_r <= rhs_r;
                st_r  <= S_POW;
              end
            end
            default: res_r <= cmd_r.imm;
          endcase
        end
        S_DIV: begin
          if (!trial[32]) begin
            rem_r <= trial[31:0];
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= {rem_r[30:0], num_r[31]};
            quo_r <= {quo_r[30:0], 1'b0};
          end
          num_r <= {num_r[30:0], 1'b0};
          it_r  <= it_r + 6'd1;
          if (it_r == 6'd31) st_r <= S_FIN2;
        end
        S_FIN2: begin
          res_r <= neg_r ? -quo_r : quo_r;
          st_r  <= S_PUSH;
        end
        S_POW: begin
          // square-and-multiply for ^, one exponent bit per cycle; * is a single multiply
          if (ex_r == 32'd0) begin
            res_r <= (cmd_r.op == OP_MUL) ? res_r : acc_r;
            st_r  <= S_PUSH;
          end else if (cmd_r.op == OP_MUL) begin
            res_r <= mul_a[31:0];
            ex_r  <= 32'd0;
          end else begin
            if (ex_r[0]) acc_r <= mul_a[31:0];
            base_r <= mul_b[31:0];
            ex_r   <= {1'b0, ex_r[31:1]};
          end
        end
        S_PUSH: begin
          if (cnt_r < DEPTH_C) cnt_r <= cnt_r + CW'(1);
          else if (err_r == ST_OK) err_r <= ST_OVERFLOW;
          st_r <= cmd_r.last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          pop_ok_r <= can_pop;
          if (!can_pop && err_r == ST_OK) err_r <= ST_UNDERFLOW;
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_r.value  <= pop_ok_r ? rdata_r : ALL_ONES;
          out_r.status <= err_r;
          out_v_r <= 1'b1;
          cnt_r   <= '0;
          err_r   <= ST_OK;
          st_r    <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/postfix_expression_evaluator_unit.sv]
// Top level of the postfix expression evaluator.
//   channel | ports                    | request
//   input   | in_push, in_full, in_req | symbol, end_of_expression
//   result  | out_pop, out_empty, out_res | value, status
// Requests execute one at a time in the back end; / is iterative (one quotient bit per
// cycle) and ^ loops (one exponent bit per cycle).
// An end request adds a final pop of the result. rst_n is synchronous.
// A two-entry command queue keeps input open while the execute unit works;
// a new request executes only once the previous result is taken.
module postfix_expression_evaluator_unit import pee_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  pee_in_t  in_req,
  output logic     in_full,
  output logic     out_empty,
  input  logic     out_pop,
  output pee_out_t out_res
);

  logic     cmd_valid, cmd_take;
  pee_cmd_t cmd;

  pee_front u_front (
    .clk, .rst_n, .in_push, .in_req, .in_full,
    .cmd_valid, .cmd, .cmd_take
  );

  pee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
    .out_empty, .out_pop, .out_res
  );

endmodule
